/* hdl/sskl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskl_pkg
// Shared constants and types for the stereo soft-knee limiter.
// ----------------------------------------------------------------------------
package sskl_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int THR_W       = 20;
   localparam int GAIN_W      = 7;
   localparam int HOLD_W      = 16;
   localparam int Q_BITS      = 16;

   // magnitude / knee level width, product width
   localparam int MAG_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS + 1 : THR_W + 1;
   localparam int PRD_W = MAG_W + GAIN_W;
   localparam int CNT_W = $clog2(PRD_W);
   localparam int REM_W = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_STEP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_LENGTH = 2'd2;

   localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(655360);
   localparam logic [GAIN_W-1:0] GAIN_STEP_RST   = GAIN_W'(10);
   localparam logic [HOLD_W-1:0] HOLD_LENGTH_RST = HOLD_W'(10000);

   localparam logic [MAG_W-1:0]   ONE_Q16     = MAG_W'(65536);
   localparam logic [PRD_W-1:0]   TEN_VOLTS   = PRD_W'(655360);
   localparam logic [REM_W:0]     DIVISOR_TEN = (REM_W + 1)'(10);
   localparam logic [PRD_W-1:0]   SAT_MAX     = PRD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [PRD_W-1:0]   SAT_MIN_MAG = PRD_W'(64'd1 << (SAMPLE_BITS - 1));

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_a;
      logic signed [SAMPLE_BITS-1:0] sample_b;
      logic                          present_a;
      logic                          present_b;
   } sskl_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] result_a;
      logic signed [SAMPLE_BITS-1:0] result_b;
      logic                          knee_light;
      logic                          clip_light;
   } sskl_rsp_type;

   typedef struct packed {
      logic done;
      logic knee;
      logic over;
   } sskl_lane_status_type;

endpackage

/* hdl/stereo_soft_knee_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_soft_knee_limiter_core
// Two-channel soft-knee limiter with knee and over-range hold lights.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stereo sample transaction (samples plus connect flags).
//   rsp_*  : one limited stereo transaction plus the two indicator lights.
//   csr_*  : register writes (0 threshold, 1 gain_step, 2 hold_length);
//            csr_ready is high outside reset, other indexes are ignored.
//   Both channels run in parallel lanes, each a bit-serial datapath:
//   knee division, shift-add gain, divide by ten, plus select and
//   saturate steps. A new request is taken only once both lanes have
//   handed their results to the output register, so one transaction
//   is in flight at a time. The serial divide by ten is the longest
//   step.
//   The result waits in an output register while rsp_stall is high; the
//   lanes may finish the next transaction meanwhile and hold it until the
//   register frees. req_stall is high while a transaction is in flight.
//   Synchronous reset restores register defaults (10 V, gain 10 tenths,
//   hold 10000) and clears the hold counters.
// ----------------------------------------------------------------------------
module stereo_soft_knee_limiter_core
   import sskl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sskl_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sskl_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [THR_W-1:0]      thr_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [HOLD_W-1:0]     hold_ff;
   logic [HOLD_W-1:0]     knee_hold_ff, knee_hold_in;
   logic [HOLD_W-1:0]     over_hold_ff, over_hold_in;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sskl_rsp_type          rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  take;
   sskl_lane_status_type  st_a, st_b;
   logic [SAMPLE_BITS-1:0] res_a, res_b;
   logic [HOLD_W-1:0]     knee_nx, over_nx;
   logic                  knee_on, over_on;

   assign req_stall = busy_ff | reset;
   assign csr_ready = ~reset;
   assign accept    = req_valid & ~req_stall;
   assign take      = busy_ff & st_a.done & st_b.done & (~rsp_valid_ff | ~rsp_stall);

   sskl_lane u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .sample    (req_data.sample_a),
      .present   (req_data.present_a),
      .threshold (thr_ff),
      .gain_step (gain_ff),
      .take      (take),
      .status    (st_a),
      .result    (res_a)
   );

   sskl_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .sample    (req_data.sample_b),
      .present   (req_data.present_b),
      .threshold (thr_ff),
      .gain_step (gain_ff),
      .take      (take),
      .status    (st_b),
      .result    (res_b)
   );

   always_comb begin
      knee_nx = (st_a.knee | st_b.knee) ? hold_ff : knee_hold_ff;
      over_nx = (st_a.over | st_b.over) ? hold_ff : over_hold_ff;
      knee_on = (knee_nx != '0);
      over_on = (over_nx != '0);

      knee_hold_in = knee_hold_ff;
      over_hold_in = over_hold_ff;
      rsp_data_in  = rsp_data_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (accept) begin
         busy_in = 1'b1;
      end
      if (take) begin
         busy_in                = 1'b0;
         rsp_valid_in           = 1'b1;
         knee_hold_in           = knee_on ? knee_nx - HOLD_W'(1) : '0;
         over_hold_in           = over_on ? over_nx - HOLD_W'(1) : '0;
         rsp_data_in.result_a   = res_a;
         rsp_data_in.result_b   = res_b;
         rsp_data_in.knee_light = knee_on;
         rsp_data_in.clip_light = over_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RST;
         gain_ff      <= GAIN_STEP_RST;
         hold_ff      <= HOLD_LENGTH_RST;
         knee_hold_ff <= '0;
         over_hold_ff <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid & csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD:   thr_ff  <= csr_wdata[THR_W-1:0];
               CSR_GAIN_STEP:   gain_ff <= csr_wdata[GAIN_W-1:0];
               CSR_HOLD_LENGTH: hold_ff <= csr_wdata[HOLD_W-1:0];
               default: begin
               end
            endcase
         end
         knee_hold_ff <= knee_hold_in;
         over_hold_ff <= over_hold_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/sskl_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskl_lane
// One limiter channel: bit-serial knee divider, shift-add gain multiply,
// bit-serial divide by ten, then saturation.
// ----------------------------------------------------------------------------
module sskl_lane
   import sskl_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          present,
   input  logic [THR_W-1:0]              threshold,
   input  logic [GAIN_W-1:0]             gain_step,
   input  logic                          take,
   output sskl_lane_status_type          status,
   output logic signed [SAMPLE_BITS-1:0] result
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SEL, ST_MUL, ST_DV10, ST_SAT, ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    knee_ff, knee_in;
   logic                    present_ff, present_in;
   logic                    over_ff, over_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [MAG_W-1:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]        den_ff, den_in;
   logic [Q_BITS-1:0]       quo_ff, quo_in;
   logic [PRD_W-1:0]        mcand_ff, mcand_in;
   logic [GAIN_W-1:0]       mplier_ff, mplier_in;
   logic [PRD_W-1:0]        acc_ff, acc_in;
   logic [REM_W-1:0]        r10_ff, r10_in;
   logic [SAMPLE_BITS-1:0]  result_ff, result_in;

   logic [SAMPLE_BITS-1:0]  raw;
   logic [MAG_W-1:0]        mag_now;
   logic [MAG_W-1:0]        diff;
   logic [MAG_W:0]          rem2;
   logic [MAG_W:0]          rem2_sub;
   logic [REM_W:0]          t5;
   logic [SAMPLE_BITS-1:0]  sat_val;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      knee_in    = knee_ff;
      present_in = present_ff;
      over_in    = over_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      quo_in     = quo_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      acc_in     = acc_ff;
      r10_in     = r10_ff;
      result_in  = result_ff;

      raw      = sample;
      mag_now  = raw[SAMPLE_BITS-1] ? MAG_W'(SAMPLE_BITS'(~raw + SAMPLE_BITS'(1)))
                                     : MAG_W'(raw);
      diff     = mag_now - MAG_W'(threshold);
      rem2     = {rem_ff, 1'b0};
      rem2_sub = rem2 - {1'b0, den_ff};
      t5       = {r10_ff, acc_ff[PRD_W-1]};

      if (neg_ff) begin
         if (acc_ff > SAT_MIN_MAG) begin
            sat_val = SAMPLE_BITS'(SAT_MIN_MAG);
         end else begin
            sat_val = SAMPLE_BITS'(~acc_ff + PRD_W'(1));
         end
      end else begin
         if (acc_ff > SAT_MAX) begin
            sat_val = SAMPLE_BITS'(SAT_MAX);
         end else begin
            sat_val = acc_ff[SAMPLE_BITS-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               present_in = present;
               neg_in     = present & raw[SAMPLE_BITS-1];
               knee_in    = present & (mag_now > MAG_W'(threshold));
               mag_in     = mag_now;
               rem_in     = diff;
               den_in     = diff + ONE_Q16;
               quo_in     = '0;
               cnt_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = rem2_sub[MAG_W-1:0];
               quo_in = {quo_ff[Q_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem2[MAG_W-1:0];
               quo_in = {quo_ff[Q_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_BITS - 1)) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            if (!present_ff) begin
               mcand_in = PRD_W'(ONE_Q16);
            end else if (knee_ff) begin
               mcand_in = PRD_W'(threshold) + PRD_W'(quo_ff);
            end else begin
               mcand_in = PRD_W'(mag_ff);
            end
            mplier_in = gain_step;
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[PRD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[GAIN_W-1:1]};
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               cnt_in   = '0;
               r10_in   = '0;
               state_in = ST_DV10;
            end
         end
         ST_DV10: begin
            if (t5 >= DIVISOR_TEN) begin
               r10_in = REM_W'(t5 - DIVISOR_TEN);
               acc_in = {acc_ff[PRD_W-2:0], 1'b1};
            end else begin
               r10_in = t5[REM_W-1:0];
               acc_in = {acc_ff[PRD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PRD_W - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            result_in = sat_val;
            over_in   = present_ff & ~neg_ff & (PRD_W'(sat_val) > TEN_VOLTS);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      knee_ff    <= knee_in;
      present_ff <= present_in;
      over_ff    <= over_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      quo_ff     <= quo_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      r10_ff     <= r10_in;
      result_ff  <= result_in;
   end

   assign status.done = (state_ff == ST_DONE);
   assign status.knee = knee_ff;
   assign status.over = over_ff;
   assign result      = result_ff;

endmodule

/* hdl/sskl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sskl_checker
// Port-level assertions for the limiter core, bound to the top level.
// ----------------------------------------------------------------------------
module sskl_checker
   import sskl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input sskl_rsp_type rsp_data
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // one transaction in flight: no request taken right after another
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // serial datapath: a result never appears right after a request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early after request");

endmodule

bind stereo_soft_knee_limiter_core sskl_checker u_sskl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
